FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define C2HI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define C2HI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/c2hi_pkg.sv
// ----------------------------------------------------------------------------
// c2hi_pkg
// Types, constants and arithmetic helpers of the two-segment Hermite
// interpolator.
// ----------------------------------------------------------------------------
package c2hi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 4;
    localparam int MAG_W         = 33;
    localparam int DEN_W         = 33;

    localparam logic signed [67:0] S32_MAX_EXT = 68'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [67:0] S32_MIN_EXT = -S32_MAX_EXT - 68'sd1;

    typedef struct packed {
        logic [32:0] rem;
        logic [32:0] q;
        logic        ovf;
    } t_div_st;

    typedef struct packed {
        logic signed [31:0] xa;
        logic signed [31:0] pa;
        logic [DEN_W-1:0]   h;
        logic signed [31:0] m0;
        logic signed [31:0] a2;
        logic signed [31:0] a3;
    } t_seg;

    typedef struct packed {
        t_seg [1:0]         seg;
        logic signed [31:0] x1;
        logic               deg;
    } t_coef;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX_EXT) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN_EXT) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    // Product rounded half up to the fixed-point grid, then saturated.
    function automatic logic signed [31:0] mulq_fin(input logic signed [67:0] p,
                                                    input int unsigned frac);
        logic signed [67:0] r;
        r = (p + (68'sd1 <<< (frac - 1))) >>> frac;
        return sat32(r);
    endfunction

    // One restoring division step: one dividend bit in, one quotient bit out.
    function automatic t_div_st div_step(input t_div_st s, input logic b,
                                         input logic [DEN_W-1:0] den);
        logic [33:0] r2;
        logic        qb;
        t_div_st     n;
        r2 = {s.rem, b};
        if (r2 >= {1'b0, den}) begin
            r2 = r2 - {1'b0, den};
            qb = 1'b1;
        end else begin
            qb = 1'b0;
        end
        n.rem = r2[32:0];
        n.q   = {s.q[31:0], qb};
        n.ovf = s.ovf | s.q[32];
        return n;
    endfunction

    // Applies the sign and saturates the quotient to 32 bits.
    function automatic logic signed [31:0] div_fin(input t_div_st s, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (s.ovf || (s.q > 33'h0_8000_0000)) begin
                r = 32'sh8000_0000;
            end else begin
                r = 32'(-s.q);
            end
        end else begin
            if (s.ovf || (s.q >= 33'h0_8000_0000)) begin
                r = 32'sh7FFF_FFFF;
            end else begin
                r = 32'(s.q);
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/c2hi_tdiv.sv
// ----------------------------------------------------------------------------
// c2hi_tdiv
// Pipelined restoring divider for the segment parameter, one quotient bit
// per stage, with saturation of the signed result to 32 bits.
// ----------------------------------------------------------------------------
module c2hi_tdiv import c2hi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_tag,
    input  logic               i_neg,
    input  logic [MAG_W-1:0]   i_mag,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_valid,
    output logic               o_tag,
    output logic signed [31:0] o_quot
);

    localparam int NB = MAG_W + FRAC_BITS;

    logic             r_v   [NB];
    logic             r_tag [NB];
    logic             r_neg [NB];
    logic [MAG_W-1:0] r_mag [NB];
    logic [DEN_W-1:0] r_den [NB];
    t_div_st          r_st  [NB];

    genvar k;
    for (k = 0; k < NB; k++) begin : g_stage
        logic             p_v;
        logic             p_tag;
        logic             p_neg;
        logic [MAG_W-1:0] p_mag;
        logic [DEN_W-1:0] p_den;
        t_div_st          p_st;
        logic             p_bit;

        if (k == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_tag = i_tag;
            assign p_neg = i_neg;
            assign p_mag = i_mag;
            assign p_den = i_den;
            assign p_st  = '0;
        end else begin : g_next
            assign p_v   = r_v[k-1];
            assign p_tag = r_tag[k-1];
            assign p_neg = r_neg[k-1];
            assign p_mag = r_mag[k-1];
            assign p_den = r_den[k-1];
            assign p_st  = r_st[k-1];
        end

        if (k < MAG_W) begin : g_mbit
            assign p_bit = p_mag[MAG_W-1-k];
        end else begin : g_zbit
            assign p_bit = 1'b0;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k] <= p_tag;
            r_neg[k] <= p_neg;
            r_mag[k] <= p_mag;
            r_den[k] <= p_den;
            r_st[k]  <= div_step(p_st, p_bit, p_den);
        end
    end

    assign o_valid = r_v[NB-1];
    assign o_tag   = r_tag[NB-1];
    assign o_quot  = div_fin(r_st[NB-1], r_neg[NB-1]);

endmodule

FILE: sv/c2hi_coef.sv
// ----------------------------------------------------------------------------
// c2hi_coef
// Configuration registers and a sequencer that derives the middle-knot
// slope and the per-segment cubic coefficients with one serial divider and
// one shared multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c2hi_coef import c2hi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_busy,
    output t_coef                o_coef
);

    localparam int NB       = MAG_W + FRAC_BITS;
    localparam int CNT_W    = $clog2(NB);
    localparam int NUM_REGS = 8;

    localparam logic [2:0] REG_X0 = 3'd0;
    localparam logic [2:0] REG_X1 = 3'd1;
    localparam logic [2:0] REG_X2 = 3'd2;
    localparam logic [2:0] REG_P0 = 3'd3;
    localparam logic [2:0] REG_P1 = 3'd4;
    localparam logic [2:0] REG_P2 = 3'd5;
    localparam logic [2:0] REG_V0 = 3'd6;
    localparam logic [2:0] REG_V2 = 3'd7;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVLD = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_MULW  = 3'd4;

    localparam logic [3:0] OP_S0   = 4'd0;
    localparam logic [3:0] OP_S1   = 4'd1;
    localparam logic [3:0] OP_W0   = 4'd2;
    localparam logic [3:0] OP_T0W  = 4'd3;
    localparam logic [3:0] OP_T1W  = 4'd4;
    localparam logic [3:0] OP_M00  = 4'd5;
    localparam logic [3:0] OP_M10  = 4'd6;
    localparam logic [3:0] OP_M01  = 4'd7;
    localparam logic [3:0] OP_M11  = 4'd8;
    localparam logic [3:0] OP_LAST = OP_M11;

    logic signed [31:0] r_cfg [NUM_REGS];
    logic [2:0]         r_state;
    logic [3:0]         r_op;
    logic               r_go;
    logic [CNT_W-1:0]   r_cnt;
    t_div_st            r_div;
    t_div_st            n_div;
    logic [MAG_W-1:0]   r_dmag;
    logic               r_dneg;
    logic [DEN_W-1:0]   r_dden;
    logic signed [31:0] r_s0;
    logic signed [31:0] r_s1;
    logic signed [31:0] r_w0;
    logic signed [31:0] r_v1;
    logic signed [31:0] r_m0;
    logic signed [67:0] r_prod;
    logic signed [67:0] r_acc;
    logic signed [31:0] r_sm0 [2];
    logic signed [31:0] r_sa2 [2];
    logic signed [31:0] r_sa3 [2];

    logic signed [31:0] x0, x1, x2, p0, p1, p2, v0, v2;
    logic signed [32:0] h0, h1, hs;
    logic signed [32:0] num;
    logic [DEN_W-1:0]   den;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic signed [31:0] q_fin;
    logic signed [31:0] t0, t1, w1, m1, a2, a3;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] d;
    logic               wr;

    assign wr = i_cfg_valid;

    assign x0 = r_cfg[REG_X0];
    assign x1 = r_cfg[REG_X1];
    assign x2 = r_cfg[REG_X2];
    assign p0 = r_cfg[REG_P0];
    assign p1 = r_cfg[REG_P1];
    assign p2 = r_cfg[REG_P2];
    assign v0 = r_cfg[REG_V0];
    assign v2 = r_cfg[REG_V2];

    assign h0 = 33'(x1) - 33'(x0);
    assign h1 = 33'(x2) - 33'(x1);
    assign hs = 33'(x2) - 33'(x0);

    always_comb begin
        case (r_op)
            OP_S0: begin
                num = 33'(p1) - 33'(p0);
                den = h0;
            end
            OP_S1: begin
                num = 33'(p2) - 33'(p1);
                den = h1;
            end
            default: begin
                num = h1;
                den = hs;
            end
        endcase
    end

    assign neg   = num[32];
    assign mag   = neg ? 33'(-num) : 33'(num);
    assign n_div = div_step(r_div, r_dmag[MAG_W-1], r_dden);
    assign q_fin = div_fin(n_div, r_dneg);

    assign t0 = sat32(68'(r_s0) + 68'(r_s0) + 68'(r_s0) - 68'(v0));
    assign t1 = sat32(68'(r_s1) + 68'(r_s1) + 68'(r_s1) - 68'(v2));
    assign w1 = (32'sd1 <<< FRAC_BITS) - r_w0;

    always_comb begin
        case (r_op)
            OP_T0W: begin
                mul_a = 34'(r_w0);
                mul_b = 34'(t0);
            end
            OP_T1W: begin
                mul_a = 34'(w1);
                mul_b = 34'(t1);
            end
            OP_M00: begin
                mul_a = 34'(v0);
                mul_b = 34'(h0);
            end
            OP_M10: begin
                mul_a = 34'(r_v1);
                mul_b = 34'(h0);
            end
            OP_M01: begin
                mul_a = 34'(r_v1);
                mul_b = 34'(h1);
            end
            default: begin
                mul_a = 34'(v2);
                mul_b = 34'(h1);
            end
        endcase
    end

    assign m1 = mulq_fin(r_prod, FRAC_BITS);
    assign d  = (r_op == OP_M10) ? (68'(p1) - 68'(p0)) : (68'(p2) - 68'(p1));
    assign a2 = sat32(d + d + d - 68'(r_m0) - 68'(r_m0) - 68'(m1));
    assign a3 = sat32(68'(r_m0) + 68'(m1) - d - d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_go          <= 1'b1;
            r_op          <= OP_S0;
            r_cnt         <= '0;
            r_cfg[REG_X0] <= 32'sh0000_0000;
            r_cfg[REG_X1] <= 32'sh0001_0000;
            r_cfg[REG_X2] <= 32'sh0002_0000;
            r_cfg[REG_P0] <= 32'sh0000_0000;
            r_cfg[REG_P1] <= 32'sh0000_0000;
            r_cfg[REG_P2] <= 32'sh0000_0000;
            r_cfg[REG_V0] <= 32'sh0000_0000;
            r_cfg[REG_V2] <= 32'sh0000_0000;
        end else if (wr) begin
            if (i_cfg_index < CFG_IDX_W'(NUM_REGS)) begin
                r_cfg[i_cfg_index[2:0]] <= i_cfg_data;
            end
            r_go    <= 1'b1;
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (r_go) begin
                        r_go    <= 1'b0;
                        r_op    <= OP_S0;
                        r_state <= ST_DIVLD;
                    end
                end
                ST_DIVLD: begin
                    r_div   <= '0;
                    r_dmag  <= mag;
                    r_dneg  <= neg;
                    r_dden  <= den;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_div  <= n_div;
                    r_dmag <= r_dmag << 1;
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(NB - 1)) begin
                        case (r_op)
                            OP_S0:   r_s0 <= q_fin;
                            OP_S1:   r_s1 <= q_fin;
                            default: r_w0 <= q_fin;
                        endcase
                        r_op    <= r_op + 4'd1;
                        r_state <= (r_op == OP_W0) ? ST_MUL : ST_DIVLD;
                    end
                end
                ST_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= ST_MULW;
                end
                ST_MULW: begin
                    case (r_op)
                        OP_T0W: r_acc <= r_prod;
                        OP_T1W: r_v1 <= sat32((r_acc + r_prod + (68'sd1 <<< FRAC_BITS))
                                              >>> (FRAC_BITS + 1));
                        OP_M00: r_m0 <= m1;
                        OP_M10: begin
                            r_sm0[0] <= r_m0;
                            r_sa2[0] <= a2;
                            r_sa3[0] <= a3;
                        end
                        OP_M01: r_m0 <= m1;
                        default: begin
                            r_sm0[1] <= r_m0;
                            r_sa2[1] <= a2;
                            r_sa3[1] <= a3;
                        end
                    endcase
                    if (r_op == OP_LAST) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_op    <= r_op + 4'd1;
                        r_state <= ST_MUL;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy = r_go || (r_state != ST_IDLE);

    always_comb begin
        o_coef.seg[0].xa = x0;
        o_coef.seg[0].pa = p0;
        o_coef.seg[0].h  = h0;
        o_coef.seg[0].m0 = r_sm0[0];
        o_coef.seg[0].a2 = r_sa2[0];
        o_coef.seg[0].a3 = r_sa3[0];
        o_coef.seg[1].xa = x1;
        o_coef.seg[1].pa = p1;
        o_coef.seg[1].h  = h1;
        o_coef.seg[1].m0 = r_sm0[1];
        o_coef.seg[1].a2 = r_sa2[1];
        o_coef.seg[1].a3 = r_sa3[1];
        o_coef.x1        = x1;
        o_coef.deg       = (h0 <= 33'sd0) || (h1 <= 33'sd0);
    end

    `C2HI_ASSERT(a_wr_sets_busy, wr |=> o_busy, "configuration write did not raise busy")
    `C2HI_ASSERT(a_done_clears_busy,
        (r_state == ST_MULW) && (r_op == OP_LAST) && !wr |=> !o_busy,
        "busy held after the last coefficient step")
    `C2HI_ASSERT(a_busy_falls_at_end, $fell(o_busy) |-> $past(r_state == ST_MULW),
        "busy dropped outside the last coefficient step")
    `C2HI_ASSERT_ALWAYS(a_cnt_range, (r_state == ST_DIV) |-> (r_cnt <= CNT_W'(NB - 1)),
        "divider step count out of range")

endmodule

FILE: sv/two_segment_c2_hermite_interpolator_core.sv
// ----------------------------------------------------------------------------
// two_segment_c2_hermite_interpolator_core
// Evaluates a two-segment cubic Hermite curve with a continuous second
// derivative at one query abscissa per request.
// ----------------------------------------------------------------------------
// One request is taken in every cycle in which start is high and busy is
// low, and its result appears on o_position and o_degenerate with o_valid
// high for exactly one cycle (values in Q16.16 at the default FRAC_BITS);
// the receiver cannot stall and results come back in request order.
// The segment-parameter divider retires one quotient bit per pipeline
// stage over 33 + FRAC_BITS stages and is followed by three multiply and
// accumulate steps of two stages each. After reset and after every
// configuration write, busy stays high while the coefficient sequencer
// runs three serial divisions and six multiplies; the configuration port
// is always ready and a new write restarts that sequence.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_segment_c2_hermite_interpolator_core import c2hi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   i_query_x,
    output logic                 o_valid,
    output logic signed [31:0]   o_position,
    output logic                 o_degenerate,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int NB  = MAG_W + FRAC_BITS;
    localparam int LAT = NB + 8;

    t_coef              coef;
    logic               accept;
    logic               sel;
    logic signed [32:0] num;
    logic               d_valid;
    logic               d_tag;
    logic signed [31:0] d_quot;

    logic               r_in_v, r_in_sel, r_in_neg;
    logic [MAG_W-1:0]   r_in_mag;
    logic [DEN_W-1:0]   r_in_den;

    logic               r_f_v, r_f_sel;
    logic signed [31:0] r_f_t;
    logic               r_m1_v, r_m1_sel;
    logic signed [31:0] r_m1_t;
    logic signed [63:0] r_m1_p;
    logic               r_a1_v, r_a1_sel;
    logic signed [31:0] r_a1_t, r_a1_acc;
    logic               r_m2_v, r_m2_sel;
    logic signed [31:0] r_m2_t;
    logic signed [63:0] r_m2_p;
    logic               r_a2_v, r_a2_sel;
    logic signed [31:0] r_a2_t, r_a2_acc;
    logic               r_m3_v, r_m3_sel;
    logic signed [63:0] r_m3_p;

    logic signed [31:0] c_a3, c_a2, c_m0, c_pa;
    logic signed [31:0] pos;

    c2hi_coef #(
        .FRAC_BITS (FRAC_BITS)
    ) u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_coef      (coef)
    );

    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // The first segment serves queries at or before the middle knot.
    assign sel = !(i_query_x <= coef.x1);
    assign num = 33'(i_query_x) - 33'(coef.seg[sel].xa);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_f_v  <= 1'b0;
            r_m1_v <= 1'b0;
            r_a1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_a2_v <= 1'b0;
            r_m3_v <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_in_v  <= accept;
            r_f_v   <= d_valid;
            r_m1_v  <= r_f_v;
            r_a1_v  <= r_m1_v;
            r_m2_v  <= r_a1_v;
            r_a2_v  <= r_m2_v;
            r_m3_v  <= r_a2_v;
            o_valid <= r_m3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_sel <= sel;
        r_in_neg <= num[32];
        r_in_mag <= num[32] ? 33'(-num) : 33'(num);
        r_in_den <= coef.seg[sel].h;
    end

    c2hi_tdiv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_tag   (r_in_sel),
        .i_neg   (r_in_neg),
        .i_mag   (r_in_mag),
        .i_den   (r_in_den),
        .o_valid (d_valid),
        .o_tag   (d_tag),
        .o_quot  (d_quot)
    );

    assign c_a3 = coef.seg[r_f_sel].a3;
    assign c_a2 = coef.seg[r_m1_sel].a2;
    assign c_m0 = coef.seg[r_m2_sel].m0;
    assign c_pa = coef.seg[r_m3_sel].pa;
    assign pos  = sat32(68'(c_pa) + 68'(mulq_fin(68'(r_m3_p), FRAC_BITS)));

    always_ff @(posedge i_clk) begin
        r_f_sel  <= d_tag;
        r_f_t    <= d_quot;

        r_m1_sel <= r_f_sel;
        r_m1_t   <= r_f_t;
        r_m1_p   <= c_a3 * r_f_t;

        r_a1_sel <= r_m1_sel;
        r_a1_t   <= r_m1_t;
        r_a1_acc <= sat32(68'(c_a2) + 68'(mulq_fin(68'(r_m1_p), FRAC_BITS)));

        r_m2_sel <= r_a1_sel;
        r_m2_t   <= r_a1_t;
        r_m2_p   <= r_a1_acc * r_a1_t;

        r_a2_sel <= r_m2_sel;
        r_a2_t   <= r_m2_t;
        r_a2_acc <= sat32(68'(c_m0) + 68'(mulq_fin(68'(r_m2_p), FRAC_BITS)));

        r_m3_sel <= r_a2_sel;
        r_m3_p   <= r_a2_acc * r_a2_t;

        o_position   <= coef.deg ? 32'sd0 : pos;
        o_degenerate <= coef.deg;
    end

    `C2HI_ASSERT(a_request_gives_result, accept |-> ##LAT o_valid,
        "accepted request produced no result")
    `C2HI_ASSERT(a_result_has_request, o_valid |-> $past(accept, LAT),
        "result without a matching request")
    `C2HI_ASSERT(a_degenerate_zero, o_valid && o_degenerate |-> (o_position == 32'sd0),
        "degenerate result with nonzero position")

endmodule

FILE: test/tb_two_segment_c2_hermite_interpolator_core.sv
// ----------------------------------------------------------------------------
// tb_two_segment_c2_hermite_interpolator_core
// Sends query abscissas to the interpolator under several knot settings,
// predicts every position and degenerate flag, and compares them in order.
// ----------------------------------------------------------------------------
module tb_two_segment_c2_hermite_interpolator_core;
    import c2hi_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint NEG_MIN = -64'sd2147483648;

    typedef enum int {
        REG_KNOT_START_X = 0,
        REG_KNOT_MID_X   = 1,
        REG_KNOT_END_X   = 2,
        REG_POS_START    = 3,
        REG_POS_MID      = 4,
        REG_POS_END      = 5,
        REG_VEL_START    = 6,
        REG_VEL_END      = 7,
        REG_UNUSED       = 9
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] position;
        logic               degenerate;
    } t_sample;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [31:0]   i_query_x = '0;
    logic                 o_valid;
    logic signed [31:0]   o_position;
    logic                 o_degenerate;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    logic [31:0] knot_regs [8];
    t_sample     expected_samples[$];
    int          mismatches = 0;
    bit          idle_on = 1'b1;

    two_segment_c2_hermite_interpolator_core u_top (.*);

    always #6 i_clk = ~i_clk;

    function automatic longint clamp32(longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < NEG_MIN) return NEG_MIN;
        return v;
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        longint p;
        p = a * b + (longint'(1) <<< (FRAC - 1));
        return clamp32(p >>> FRAC);
    endfunction

    function automatic longint fix_div(longint num, longint den);
        return clamp32((num * (longint'(1) <<< FRAC)) / den);
    endfunction

    function automatic longint eval_segment(longint x, longint xa, longint h, longint pa,
                                            longint pb, longint va, longint vb);
        longint t, m0, m1, d, a2, a3, acc;
        t   = fix_div(x - xa, h);
        m0  = fix_mul(va, h);
        m1  = fix_mul(vb, h);
        d   = pb - pa;
        a2  = clamp32(3 * d - 2 * m0 - m1);
        a3  = clamp32(m0 + m1 - 2 * d);
        acc = clamp32(a2 + fix_mul(a3, t));
        acc = clamp32(m0 + fix_mul(acc, t));
        return clamp32(pa + fix_mul(acc, t));
    endfunction

    function automatic t_sample predict_sample(logic signed [31:0] qx);
        longint x, x0, x1, x2, p0, p1, p2, v0, v2, h0, h1;
        longint s0, s1, t0, t1, w0, w1, v1;
        t_sample r;
        x  = qx;
        x0 = $signed(knot_regs[REG_KNOT_START_X]);
        x1 = $signed(knot_regs[REG_KNOT_MID_X]);
        x2 = $signed(knot_regs[REG_KNOT_END_X]);
        p0 = $signed(knot_regs[REG_POS_START]);
        p1 = $signed(knot_regs[REG_POS_MID]);
        p2 = $signed(knot_regs[REG_POS_END]);
        v0 = $signed(knot_regs[REG_VEL_START]);
        v2 = $signed(knot_regs[REG_VEL_END]);
        h0 = x1 - x0;
        h1 = x2 - x1;
        if (h0 <= 0 || h1 <= 0) begin
            r.position   = '0;
            r.degenerate = 1'b1;
            return r;
        end
        s0 = fix_div(p1 - p0, h0);
        s1 = fix_div(p2 - p1, h1);
        t0 = clamp32(3 * s0 - v0);
        t1 = clamp32(3 * s1 - v2);
        w0 = (h1 * (longint'(1) <<< FRAC)) / (h0 + h1);
        w1 = (longint'(1) <<< FRAC) - w0;
        v1 = clamp32((w0 * t0 + w1 * t1 + (longint'(1) <<< FRAC)) >>> (FRAC + 1));
        if (x <= x1) begin
            r.position = 32'(eval_segment(x, x0, h0, p0, p1, v0, v1));
        end else begin
            r.position = 32'(eval_segment(x, x1, h1, p1, p2, v1, v2));
        end
        r.degenerate = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sample exp_s;
        if (i_rst_n && o_valid) begin
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result: position %0d degenerate %0b",
                             o_position, o_degenerate);
                end
            end else begin
                exp_s = expected_samples.pop_front();
                if (o_position !== exp_s.position || o_degenerate !== exp_s.degenerate) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result mismatch: expected position %0d degenerate %0b, got %0d %0b",
                                 exp_s.position, exp_s.degenerate, o_position, o_degenerate);
                    end
                end
            end
        end
    end

    task automatic send_query(logic signed [31:0] qx);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_query_x <= qx;
        do @(posedge i_clk); while (busy);
        expected_samples.push_back(predict_sample(qx));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IDX_W'(idx);
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (int'(idx) < 8) knot_regs[idx] = data;
    endtask

    task automatic load_knots(longint x0, longint x1, longint x2, logic [31:0] p0,
                              logic [31:0] p1, logic [31:0] p2, logic [31:0] v0,
                              logic [31:0] v2);
        drain_results();
        write_reg(REG_KNOT_START_X, 32'(x0));
        write_reg(REG_KNOT_MID_X, 32'(x1));
        write_reg(REG_KNOT_END_X, 32'(x2));
        write_reg(REG_POS_START, p0);
        write_reg(REG_POS_MID, p1);
        write_reg(REG_POS_END, p2);
        write_reg(REG_VEL_START, v0);
        write_reg(REG_VEL_END, v2);
    endtask

    task automatic test_directed();
        send_query(32'sd0);
        send_query(32'sd65536);
        send_query(32'sh7FFF_FFFF);
        send_query(32'sh8000_0000);
        load_knots(-65536, 0, 131072, 32'd65536, 32'hFFFF_0000, 32'd196608,
                   32'd32768, 32'hFFFE_0000);
        send_query(32'sd0);
        send_query(32'sd1);
        send_query(-32'sd65536);
        send_query(32'sd131072);
        send_query(32'sd40000);
        send_query(32'sh7FFF_FFFF);
        send_query(32'sh8000_0000);
        load_knots(NEG_MIN, 0, POS_MAX, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF);
        send_query(32'sh8000_0000);
        send_query(32'sd0);
        send_query(32'sh7FFF_FFFF);
        send_query(32'sh4000_0000);
        load_knots(65536, 65536, 131072, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9);
        send_query(32'sd65536);
        load_knots(0, 131072, 65536, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9);
        send_query(32'sd100);
        drain_results();
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        send_query(32'sd7);
    endtask

    task automatic test_random_phases();
        longint x0, x1, x2, span;
        logic signed [31:0] qx;
        int mode;
        for (int phase = 0; phase < 20; phase++) begin
            mode    = $urandom_range(0, 9);
            idle_on = (phase % 4) != 3;
            span    = (mode < 6) ? 64'd1 << $urandom_range(4, 22) : 64'd1 << 30;
            x0 = $signed($urandom_range(0, 32'h00FF_FFFF)) - 64'sd8388608;
            x1 = x0 + $urandom_range(1, 32'(span));
            x2 = x1 + $urandom_range(1, 32'(span));
            if (mode == 8) x1 = x0 - $urandom_range(0, 3);
            if (mode == 9) x2 = x1 - $urandom_range(0, 3);
            x0 = clamp32(x0);
            x1 = clamp32(x1);
            x2 = clamp32(x2);
            if (mode == 7) begin
                load_knots(x0, x1, x2, $urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom());
            end else begin
                load_knots(x0, x1, x2, $urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
                           $urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
                           $urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
                           $urandom_range(0, 32'h7_FFFF) - 32'h4_0000,
                           $urandom_range(0, 32'h7_FFFF) - 32'h4_0000);
            end
            for (int n = 0; n < 50; n++) begin
                case ($urandom_range(0, 5))
                    0: qx = $urandom();
                    1: qx = 32'(x1);
                    2: qx = 32'(clamp32(x0 - $urandom_range(0, 32'(span))));
                    3: qx = 32'(clamp32(x2 + $urandom_range(0, 32'(span))));
                    default: qx = 32'(clamp32(x0 + $urandom_range(0, 32'(x2 - x0 > 0 ?
                                                  (x2 - x0 > POS_MAX ? POS_MAX : x2 - x0) : 0))));
                endcase
                send_query(qx);
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        knot_regs[REG_KNOT_START_X] = 32'd0;
        knot_regs[REG_KNOT_MID_X]   = 32'd65536;
        knot_regs[REG_KNOT_END_X]   = 32'd131072;
        for (int i = REG_POS_START; i <= REG_VEL_END; i++) knot_regs[i] = 32'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phases();
        drain_results();
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("two_segment_c2_hermite_interpolator_core: match");
        end else begin
            $display("two_segment_c2_hermite_interpolator_core: mismatch");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("two_segment_c2_hermite_interpolator_core: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/c2hi_pkg.sv
sv/c2hi_tdiv.sv
sv/c2hi_coef.sv
sv/two_segment_c2_hermite_interpolator_core.sv
test/tb_two_segment_c2_hermite_interpolator_core.sv
